[rtl/weighted_moving_average_unit_defines.svh]
// Assertion macros for the weighted moving average unit.
// Included by the checker module; no other dependencies.
`ifndef WEIGHTED_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define WEIGHTED_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WMA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wma assertion failed");

// Next-cycle implication, disabled during reset.
`define WMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wma assertion failed");

// Next-cycle implication that also checks across reset.
`define WMA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wma assertion failed");

`endif

[rtl/wma_pkg.sv]
// Shared constants and types for the weighted moving average unit.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package wma_pkg;

  localparam int CFG_BITS            = 7;
  localparam int DEN_BITS            = 2 * CFG_BITS - 1;
  localparam int WINDOW_LIMIT        = 2 ** CFG_BITS - 1;
  localparam int MIN_WINDOW          = 2;
  localparam int DEFAULT_MAX_WINDOW  = 64;
  localparam int DEFAULT_SAMPLE_BITS = 32;

  localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(10);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_PREP,
    S_DIV,
    S_DONE
  } wma_state_t;

endpackage

[rtl/weighted_moving_average_unit.sv]
// Linear weighted moving average over a ring of samples, with a bit-serial divider.
// Depends on wma_pkg.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_stall    sample, new_series
// out       out_valid / out_stall  average
// cfg       cfg_write              window_length
//
// An item with a result passes through these steps before the next sample is accepted:
// accept, multiply, sum update, divider setup, a divider step per weighted-sum bit, output load.
// Items that give no result return to idle after the sum update.
// Reset sets the window length to 10 and empties the window; ring contents are not cleared.
// A finished result waits in the output register; a stalled output holds the next
// result in the final state until the register frees.

module weighted_moving_average_unit import wma_pkg::*; #(
  parameter int MAX_WINDOW  = DEFAULT_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          new_series,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] average,
  input  logic                          cfg_write,
  input  logic [CFG_BITS-1:0]           window_length
);

  localparam int EFF_MAX   = (MAX_WINDOW > WINDOW_LIMIT) ? WINDOW_LIMIT : MAX_WINDOW;
  localparam int PTR_BITS  = $clog2(MAX_WINDOW);
  localparam int WSB       = SAMPLE_BITS + $clog2(EFF_MAX);
  localparam int WTB       = SAMPLE_BITS + $clog2(EFF_MAX * (EFF_MAX + 1) / 2);
  localparam int PROD_BITS = SAMPLE_BITS + CFG_BITS + 1;
  localparam int CNT_BITS  = $clog2(WTB + 1);

  wma_state_t state, state_next;

  logic [CFG_BITS-1:0]           window_len;
  logic [CFG_BITS-1:0]           n;
  logic [CFG_BITS-1:0]           fill;
  logic [PTR_BITS-1:0]           ptr;
  logic signed [WSB-1:0]         ws;
  logic signed [WTB-1:0]         wt;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic signed [SAMPLE_BITS-1:0] old_reg;
  logic [PTR_BITS-1:0]           slot;
  logic [CFG_BITS-1:0]           weight;
  logic                          full;
  logic signed [WTB-1:0]         prod;
  logic [DEN_BITS-1:0]           den;
  logic [DEN_BITS-1:0]           rem;
  logic [WTB-1:0]                quo;
  logic                          neg;
  logic [CNT_BITS-1:0]           cnt;

  logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];

  logic                          accept;
  logic                          ring_write;
  logic                          out_load;
  logic                          has_result;
  logic [CFG_BITS-1:0]           fill_eff;
  logic [PTR_BITS-1:0]           rd_addr;
  logic signed [PROD_BITS-1:0]   prod_full;
  logic [2*CFG_BITS-1:0]         tri_prod;
  logic [DEN_BITS:0]             rem_sh;
  logic signed [SAMPLE_BITS-1:0] q_trunc;

  // Clamp the programmed length to the supported range.
  always_comb begin
    if (window_len < CFG_BITS'(MIN_WINDOW)) begin
      n = CFG_BITS'(MIN_WINDOW);
    end else if (int'(window_len) > MAX_WINDOW) begin
      n = CFG_BITS'(MAX_WINDOW);
    end else begin
      n = window_len;
    end
  end

  assign fill_eff   = new_series ? '0 : fill;
  assign rd_addr    = new_series ? '0 : ptr;
  assign prod_full  = $signed({1'b0, weight}) * x_reg;
  assign tri_prod   = {{CFG_BITS{1'b0}}, n} * ({{CFG_BITS{1'b0}}, n} + 1'b1);
  assign rem_sh     = {rem, quo[WTB-1]};
  assign q_trunc    = $signed(quo[SAMPLE_BITS-1:0]);
  assign has_result = full || (CFG_BITS'(fill + 1'b1) == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    accept     = 1'b0;
    ring_write = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        ring_write = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        state_next = has_result ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (cnt == CNT_BITS'(WTB - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register can take the result.
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sample ring: read the oldest entry at accept, write the new sample in the following cycle.
  always_ff @(posedge clk) begin
    if (ring_write) begin
      ring[slot] <= x_reg;
    end
    if (accept) begin
      old_reg <= $signed(ring[rd_addr]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_RESET;
      fill       <= '0;
      ptr        <= '0;
      ws         <= '0;
      wt         <= '0;
    end else if (cfg_write) begin
      window_len <= window_length;
      fill       <= '0;
      ptr        <= '0;
      ws         <= '0;
      wt         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && new_series) begin
            fill <= '0;
            ptr  <= '0;
            ws   <= '0;
            wt   <= '0;
          end
        end
        S_SUM: begin
          if (full) begin
            wt <= wt - WTB'(ws) + prod;
            ws <= ws - WSB'(old_reg) + WSB'(x_reg);
          end else begin
            wt   <= wt + prod;
            ws   <= ws + WSB'(x_reg);
            fill <= CFG_BITS'(fill + 1'b1);
          end
          if (int'(slot) + 1 == int'(n)) begin
            ptr <= '0;
          end else begin
            ptr <= PTR_BITS'(slot + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Per-transaction datapath and the shared restoring divider.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          x_reg  <= sample;
          slot   <= rd_addr;
          full   <= (fill_eff >= n);
          weight <= (fill_eff >= n) ? n : CFG_BITS'(fill_eff + 1'b1);
        end
      end
      S_MUL: begin
        prod <= WTB'(prod_full);
      end
      S_PREP: begin
        neg <= wt[WTB-1];
        quo <= wt[WTB-1] ? unsigned'(-wt) : unsigned'(wt);
        rem <= '0;
        cnt <= '0;
        den <= tri_prod[2*CFG_BITS-1:1];
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= DEN_BITS'(rem_sh - {1'b0, den});
          quo <= {quo[WTB-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DEN_BITS-1:0];
          quo <= {quo[WTB-2:0], 1'b0};
        end
        cnt <= CNT_BITS'(cnt + 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average <= neg ? -q_trunc : q_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[rtl/wma_checker.sv]
// Port-level checker for the weighted moving average unit, bound to the top level.
// Depends on wma_pkg and weighted_moving_average_unit_defines.svh.
`timescale 1ns / 1ps
`include "weighted_moving_average_unit_defines.svh"

module wma_checker import wma_pkg::*; #(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] average
);

  // The block is busy right after taking a transaction.
  `WMA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // A result only appears at the end of a busy period.
  `WMA_ASSERT_SAME(a_result_from_busy, clk, rst, $rose(out_valid), $past(in_stall))
  // Reset drops any pending result.
  `WMA_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, rst, !out_valid)
  // Hold a stalled result.
  `WMA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(average))

endmodule

bind weighted_moving_average_unit wma_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wma_checker (.*);
